// ----- rtl/clc_pkg.sv -----
// ----------------------------------------------------------------------------
// clc_pkg: shared types for the configuration line classifier
// Character classes that pass from the front to the back, line class codes,
// and the queue head struct.
// ----------------------------------------------------------------------------
package clc_pkg;

  typedef enum logic [3:0] {
    CHR_EOL    = 4'd0,
    CHR_WS     = 4'd1,
    CHR_NL     = 4'd2,
    CHR_LBR    = 4'd3,
    CHR_RBR    = 4'd4,
    CHR_QUOTE  = 4'd5,
    CHR_EQ     = 4'd6,
    CHR_DOT    = 4'd7,
    CHR_USCORE = 4'd8,
    CHR_ALNUM  = 4'd9,
    CHR_OTHER  = 4'd10
  } chr_e;

  typedef enum logic [2:0] {
    CLS_BLANK     = 3'd0,
    CLS_HEADER    = 3'd1,
    CLS_SUBHEADER = 3'd2,
    CLS_KEYVALUE  = 3'd3,
    CLS_INVALID   = 3'd4
  } cls_e;

  localparam int unsigned DataW = 8;
  localparam int unsigned ClsW  = 3;

  typedef struct packed {
    logic valid;
    chr_e chr;
  } q_head_t;

endpackage

// ----- rtl/clc_front.sv -----
// ----------------------------------------------------------------------------
// clc_front: input side of the line classifier
// Accepts bytes, reduces each to a character class and queues the classes
// for the grammar automaton.
// ----------------------------------------------------------------------------
module clc_front import clc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [7:0] ch
  input  logic             pop_i,
  output q_head_t          head_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  chr_e            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  chr_e            chr_in;

  function automatic chr_e classify(logic [DataW-1:0] c);
    chr_e r;
    r = CHR_OTHER;
    if (c == 8'h00) r = CHR_EOL;
    else if (c == 8'h0A || c == 8'h0D) r = CHR_NL;
    else if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C) r = CHR_WS;
    else if (c == 8'h5B) r = CHR_LBR;
    else if (c == 8'h5D) r = CHR_RBR;
    else if (c == 8'h22) r = CHR_QUOTE;
    else if (c == 8'h3D) r = CHR_EQ;
    else if (c == 8'h2E) r = CHR_DOT;
    else if (c == 8'h5F) r = CHR_USCORE;
    else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A)) r = CHR_ALNUM;
    return r;
  endfunction

  assign chr_in        = classify(s_axis_tdata);
  assign s_axis_tready = (count_q != CntW'(Depth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= chr_in;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.chr   = mem_q[rd_ptr_q];
  assign count_o      = count_q;

endmodule

// ----- rtl/clc_back.sv -----
// ----------------------------------------------------------------------------
// clc_back: grammar automaton of the line classifier
// Consumes queued character classes, tracks the line grammar and drives the
// result register with one line class per end of line.
// ----------------------------------------------------------------------------
module clc_back import clc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_head_t          head_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata    // [2:0] line_class
);

  typedef enum logic [12:0] {
    PH_LEAD   = 13'b0000000000001,
    PH_BR1    = 13'b0000000000010,
    PH_HNAME  = 13'b0000000000100,
    PH_HTAIL  = 13'b0000000001000,
    PH_BR2    = 13'b0000000010000,
    PH_SNAME  = 13'b0000000100000,
    PH_SCLOSE = 13'b0000001000000,
    PH_STAIL  = 13'b0000010000000,
    PH_KEY    = 13'b0000100000000,
    PH_KEYWS  = 13'b0001000000000,
    PH_EQ     = 13'b0010000000000,
    PH_VALUE  = 13'b0100000000000,
    PH_BAD    = 13'b1000000000000
  } phase_e;

  phase_e phase_q, phase_d;
  logic   open_q, open_d, closed_q, closed_d;
  logic   out_valid_q, out_valid_d;
  cls_e   out_cls_q, out_cls_d;
  logic   is_eol, is_ws, is_name, is_key, load;
  chr_e   c;

  assign c       = head_i.chr;
  assign is_eol  = (c == CHR_EOL);
  assign is_ws   = (c == CHR_WS) || (c == CHR_NL);
  assign is_name = (c == CHR_ALNUM) || (c == CHR_DOT);
  assign is_key  = (c == CHR_ALNUM) || (c == CHR_USCORE);
  assign pop_o   = head_i.valid && (!is_eol || !out_valid_q || m_axis_tready);
  assign load    = pop_o && is_eol;

  always_comb begin
    phase_d  = phase_q;
    open_d   = open_q;
    closed_d = closed_q;
    if (pop_o && !is_eol) begin
      if (phase_q == PH_VALUE) begin
        closed_d = (open_q && c == CHR_QUOTE) || (closed_q && is_ws);
        open_d   = open_q && (c != CHR_NL);
        if (!closed_d && !open_d) phase_d = PH_BAD;
      end else begin
        case (phase_q)
          PH_LEAD: begin
            if (is_ws) phase_d = PH_LEAD;
            else if (c == CHR_LBR) phase_d = PH_BR1;
            else if (is_key) phase_d = PH_KEY;
            else phase_d = PH_BAD;
          end
          PH_BR1: begin
            if (c == CHR_LBR) phase_d = PH_BR2;
            else if (is_name) phase_d = PH_HNAME;
            else phase_d = PH_BAD;
          end
          PH_HNAME: begin
            if (is_name) phase_d = PH_HNAME;
            else if (c == CHR_RBR) phase_d = PH_HTAIL;
            else phase_d = PH_BAD;
          end
          PH_HTAIL:  phase_d = is_ws ? PH_HTAIL : PH_BAD;
          PH_BR2:    phase_d = is_name ? PH_SNAME : PH_BAD;
          PH_SNAME: begin
            if (is_name) phase_d = PH_SNAME;
            else if (c == CHR_RBR) phase_d = PH_SCLOSE;
            else phase_d = PH_BAD;
          end
          PH_SCLOSE: phase_d = (c == CHR_RBR) ? PH_STAIL : PH_BAD;
          PH_STAIL:  phase_d = is_ws ? PH_STAIL : PH_BAD;
          PH_KEY: begin
            if (is_key) phase_d = PH_KEY;
            else if (is_ws) phase_d = PH_KEYWS;
            else if (c == CHR_EQ) phase_d = PH_EQ;
            else phase_d = PH_BAD;
          end
          PH_KEYWS: begin
            if (is_ws) phase_d = PH_KEYWS;
            else if (c == CHR_EQ) phase_d = PH_EQ;
            else phase_d = PH_BAD;
          end
          PH_EQ: begin
            if (is_ws) phase_d = PH_EQ;
            else if (c == CHR_QUOTE) begin
              phase_d  = PH_VALUE;
              open_d   = 1'b1;
              closed_d = 1'b0;
            end else phase_d = PH_BAD;
          end
          default: phase_d = PH_BAD;
        endcase
      end
    end else if (load) begin
      phase_d  = PH_LEAD;
      open_d   = 1'b0;
      closed_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_cls_d   = out_cls_q;
    if (load) begin
      out_valid_d = 1'b1;
      case (phase_q)
        PH_LEAD:  out_cls_d = CLS_BLANK;
        PH_HTAIL: out_cls_d = CLS_HEADER;
        PH_STAIL: out_cls_d = CLS_SUBHEADER;
        PH_VALUE: out_cls_d = closed_q ? CLS_KEYVALUE : CLS_INVALID;
        default:  out_cls_d = CLS_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      open_q      <= 1'b0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      open_q      <= open_d;
      closed_q    <= closed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cls_q <= out_cls_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(DataW - ClsW){1'b0}}, out_cls_q};

endmodule

// ----- rtl/config_line_classifier_core.sv -----
// ----------------------------------------------------------------------------
// config_line_classifier_core: configuration line classifier
// Classifies configuration-file lines streamed one byte per transaction.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the queue has room. Each byte is
// reduced to a character class and placed in a queue of Depth entries; the
// grammar automaton drains one entry per cycle unless a stalled result
// register holds it back at an end of line. A zero byte ends a line and
// yields one line class transaction (0 blank, 1 header, 2 subheader, 3
// key/value, 4 invalid); its class is queued, then popped into the result
// register. The input keeps flowing until the queue fills.
module config_line_classifier_core import clc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [7:0] ch
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata    // [2:0] line_class, zeros above
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  q_head_t         head;
  logic            pop;
  logic [CntW-1:0] count;

  clc_front #(.Depth(Depth)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .pop_i         (pop),
    .head_o        (head),
    .count_o       (count)
  );

  clc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(pop && head.chr == CHR_EOL))
    else $error("result without end of line");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (count == CntW'(Depth)))
    else $error("input stalled with room in queue");

endmodule
